### sv/nnls_pkg.sv
// shared types, constants and state encodings of the letterbox scaler
`default_nettype none

package nnls_pkg;

  localparam int MAX_TARGET_DEF = 512;
  localparam int MAX_SOURCE_DEF = 16384;
  localparam int MAX_RUN_DEF    = 64;

  localparam int ADDR_W  = 18;
  localparam int PIXEL_W = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int SRC_REG_W = 15;
  localparam int TGT_REG_W = 10;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_SIZE   = 3'd2,
    REG_KEEP_ASPECT   = 3'd3,
    REG_PACKED_MODE   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    FR_GMUL,
    FR_GDIV,
    FR_GSET,
    FR_IDLE,
    FR_ROWS,
    FR_COLS,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] packed_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  target_address;
    logic [PIXEL_W-1:0] pixel_value;
    logic               write_enable;
    logic               last_of_run;
    logic               frame_complete;
    logic               overflow;
  } out_item_t;

endpackage

`default_nettype wire

### sv/nnls_queue.sv
// two-entry job queue between the front and the back
`default_nettype none

module nnls_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              not_empty
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   count_r, count_nxt;

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  assign dout      = mem_r[rptr_r];
  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;

endmodule

`default_nettype wire

### sv/nnls_front.sv
// front: geometry divider, pixel conversion, row and column coverage scan
`default_nettype none

module nnls_front #(
  parameter int MAX_TARGET = nnls_pkg::MAX_TARGET_DEF,
  parameter int MAX_SOURCE = nnls_pkg::MAX_SOURCE_DEF,
  parameter int MAX_RUN    = nnls_pkg::MAX_RUN_DEF,
  localparam int TW = $clog2(MAX_TARGET + 1),
  localparam int SW = $clog2(MAX_SOURCE + 1),
  localparam int RW = $clog2(MAX_RUN + 1),
  localparam int JW = 16 + 4 * TW + RW + 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               restart,
  input  wire logic [SW-1:0]      eff_w,
  input  wire logic [SW-1:0]      eff_h,
  input  wire logic [TW-1:0]      eff_t,
  input  wire logic               keep_aspect,
  input  wire logic               packed_mode,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire nnls_pkg::in_item_t in_item,
  output logic                    q_push,
  output logic [JW-1:0]           q_data,
  input  wire logic               q_full,
  output logic [TW-2:0]           margin_x,
  output logic [TW-2:0]           margin_y
);

  import nnls_pkg::*;

  localparam int AW = SW + TW;
  localparam int PW = 2 * TW;
  localparam int CW = $clog2(AW);

  typedef struct packed {
    logic [15:0]   pixel;
    logic [TW-1:0] row_first;
    logic [TW-1:0] row_count;
    logic [TW-1:0] col_first;
    logic [TW-1:0] col_count;
    logic [RW-1:0] run_len;
    logic          ovf;
    logic          last;
    logic          complete;
  } job_t;

  front_state_t state_r, state_nxt;

  logic [SW-1:0] sc_r, sc_nxt, sr_r, sr_nxt;
  logic [TW-1:0] ntr_r, ntr_nxt, ntc_r, ntc_nxt;
  logic [AW-1:0] row_acc_r, row_acc_nxt, row_lim_r, row_lim_nxt;
  logic [AW-1:0] col_acc_r, col_acc_nxt, col_lim_r, col_lim_nxt;
  logic [TW-1:0] rf_r, rf_nxt, rc_r, rc_nxt, cf_r, cf_nxt, cc_r, cc_nxt;
  logic [15:0]   pix_r, pix_nxt;
  logic [PW-1:0] total_r, total_nxt;
  logic          last_r, last_nxt, complete_r, complete_nxt;
  logic [TW-1:0] dw_r, dw_nxt, dh_r, dh_nxt;
  logic [TW-2:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [AW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [SW-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [CW-1:0] dcnt_r, dcnt_nxt;

  logic          accept;
  logic          row_hit, col_hit;
  logic          ovf;
  logic          need_push;
  logic          advance;
  logic          w_ge_h;
  logic [SW-1:0] short_side, long_side;
  logic [SW:0]   shifted;
  logic          qbit;
  logic [TW-1:0] scaled, diff;
  logic [15:0]   conv_pix;
  job_t          job;

  assign accept  = (state_r == FR_IDLE) && in_valid;
  assign row_hit = (ntr_r < dh_r) && (row_acc_r < row_lim_r);
  assign col_hit = (ntc_r < dw_r) && (col_acc_r < col_lim_r);
  assign ovf     = total_r > PW'(MAX_RUN);
  assign need_push = (total_r != '0) || last_r;
  assign advance = !need_push || !q_full;

  assign w_ge_h     = eff_w >= eff_h;
  assign short_side = w_ge_h ? eff_h : eff_w;
  assign long_side  = w_ge_h ? eff_w : eff_h;
  assign shifted    = {rem_r, num_r[AW-1]};
  assign qbit       = shifted >= {1'b0, den_r};
  assign scaled     = (TW'(quo_r) == '0) ? TW'(1) : TW'(quo_r);
  assign diff       = eff_t - scaled;

  assign conv_pix = packed_mode ? in_item.packed_pixel :
                    {in_item.red[7:3], in_item.green[7:2], in_item.blue[7:3]};

  always_comb begin
    job.pixel     = pix_r;
    job.row_first = rf_r;
    job.row_count = rc_r;
    job.col_first = cf_r;
    job.col_count = cc_r;
    job.run_len   = ovf ? RW'(MAX_RUN) : RW'(total_r);
    job.ovf       = ovf;
    job.last      = last_r;
    job.complete  = complete_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_GMUL: state_nxt = FR_GDIV;
      FR_GDIV: if (dcnt_r == '0) begin
        state_nxt = FR_GSET;
      end
      FR_GSET: state_nxt = FR_IDLE;
      FR_IDLE: if (in_valid) begin
        state_nxt = (sc_r == '0) ? FR_ROWS : FR_COLS;
      end
      FR_ROWS: if (!row_hit) begin
        state_nxt = FR_COLS;
      end
      FR_COLS: if (!col_hit) begin
        state_nxt = FR_MUL;
      end
      FR_MUL:  state_nxt = FR_PUSH;
      FR_PUSH: if (advance) begin
        state_nxt = FR_IDLE;
      end
      default: state_nxt = FR_GMUL;
    endcase
    if (restart) begin
      state_nxt = FR_GMUL;
    end
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    case (state_r)
      FR_IDLE: in_stall = 1'b0;
      FR_PUSH: q_push   = need_push && !q_full;
      default: begin
        in_stall = 1'b1;
        q_push   = 1'b0;
      end
    endcase
  end

  assign q_data   = JW'(job);
  assign margin_x = ox_r;
  assign margin_y = oy_r;

  // datapath
  always_comb begin
    sc_nxt = sc_r;           sr_nxt = sr_r;
    ntr_nxt = ntr_r;         ntc_nxt = ntc_r;
    row_acc_nxt = row_acc_r; row_lim_nxt = row_lim_r;
    col_acc_nxt = col_acc_r; col_lim_nxt = col_lim_r;
    rf_nxt = rf_r;           rc_nxt = rc_r;
    cf_nxt = cf_r;           cc_nxt = cc_r;
    pix_nxt = pix_r;         total_nxt = total_r;
    last_nxt = last_r;       complete_nxt = complete_r;
    dw_nxt = dw_r;           dh_nxt = dh_r;
    ox_nxt = ox_r;           oy_nxt = oy_r;
    num_nxt = num_r;         quo_nxt = quo_r;
    den_nxt = den_r;         rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    case (state_r)
      FR_GMUL: begin
        num_nxt  = {{TW{1'b0}}, short_side} * {{SW{1'b0}}, eff_t};
        den_nxt  = long_side;
        rem_nxt  = '0;
        quo_nxt  = '0;
        dcnt_nxt = CW'(AW - 1);
      end
      FR_GDIV: begin
        rem_nxt  = qbit ? SW'(shifted - {1'b0, den_r}) : SW'(shifted);
        quo_nxt  = {quo_r[AW-2:0], qbit};
        num_nxt  = num_r << 1;
        dcnt_nxt = dcnt_r - CW'(1);
      end
      FR_GSET: begin
        dw_nxt = eff_t;
        dh_nxt = eff_t;
        ox_nxt = '0;
        oy_nxt = '0;
        if (keep_aspect && w_ge_h) begin
          dh_nxt = scaled;
          oy_nxt = (TW-1)'(diff >> 1);
        end else if (keep_aspect) begin
          dw_nxt = scaled;
          ox_nxt = (TW-1)'(diff >> 1);
        end
        sc_nxt = '0;
        sr_nxt = '0;
        ntr_nxt = '0;
        ntc_nxt = '0;
        row_acc_nxt = '0;
        col_acc_nxt = '0;
        row_lim_nxt = AW'(dh_nxt);
        col_lim_nxt = AW'(dw_nxt);
      end
      FR_IDLE: if (accept) begin
        pix_nxt = conv_pix;
        cf_nxt  = ntc_r;
        cc_nxt  = '0;
        if (sc_r == '0) begin
          rf_nxt = ntr_r;
          rc_nxt = '0;
        end
      end
      FR_ROWS: if (row_hit) begin
        ntr_nxt     = ntr_r + TW'(1);
        row_acc_nxt = row_acc_r + AW'(eff_h);
        rc_nxt      = rc_r + TW'(1);
      end
      FR_COLS: if (col_hit) begin
        ntc_nxt     = ntc_r + TW'(1);
        col_acc_nxt = col_acc_r + AW'(eff_w);
        cc_nxt      = cc_r + TW'(1);
      end
      FR_MUL: begin
        total_nxt    = {{TW{1'b0}}, rc_r} * {{TW{1'b0}}, cc_r};
        last_nxt     = (SW'(sc_r + SW'(1)) == eff_w) && (SW'(sr_r + SW'(1)) == eff_h);
        complete_nxt = ntr_r == dh_r;
      end
      FR_PUSH: if (advance) begin
        if (last_r) begin
          sc_nxt = '0;
          sr_nxt = '0;
          ntr_nxt = '0;
          ntc_nxt = '0;
          row_acc_nxt = '0;
          col_acc_nxt = '0;
          row_lim_nxt = AW'(dh_r);
          col_lim_nxt = AW'(dw_r);
        end else if (SW'(sc_r + SW'(1)) >= eff_w) begin
          sc_nxt = '0;
          sr_nxt = sr_r + SW'(1);
          row_lim_nxt = row_lim_r + AW'(dh_r);
          ntc_nxt = '0;
          col_acc_nxt = '0;
          col_lim_nxt = AW'(dw_r);
        end else begin
          sc_nxt = sc_r + SW'(1);
          col_lim_nxt = col_lim_r + AW'(dw_r);
        end
      end
      default: begin
        sc_nxt = sc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_GMUL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;           sr_r <= sr_nxt;
    ntr_r <= ntr_nxt;         ntc_r <= ntc_nxt;
    row_acc_r <= row_acc_nxt; row_lim_r <= row_lim_nxt;
    col_acc_r <= col_acc_nxt; col_lim_r <= col_lim_nxt;
    rf_r <= rf_nxt;           rc_r <= rc_nxt;
    cf_r <= cf_nxt;           cc_r <= cc_nxt;
    pix_r <= pix_nxt;         total_r <= total_nxt;
    last_r <= last_nxt;       complete_r <= complete_nxt;
    dw_r <= dw_nxt;           dh_r <= dh_nxt;
    ox_r <= ox_nxt;           oy_r <= oy_nxt;
    num_r <= num_nxt;         quo_r <= quo_nxt;
    den_r <= den_nxt;         rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt;
  end

endmodule

`default_nettype wire

### sv/nnls_back.sv
// back: walks the covered target block and emits one write transaction per cycle while the output is not stalled
`default_nettype none

module nnls_back #(
  parameter int MAX_TARGET = nnls_pkg::MAX_TARGET_DEF,
  parameter int MAX_RUN    = nnls_pkg::MAX_RUN_DEF,
  localparam int TW = $clog2(MAX_TARGET + 1),
  localparam int RW = $clog2(MAX_RUN + 1),
  localparam int JW = 16 + 4 * TW + RW + 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic [JW-1:0]     q_data,
  input  wire logic [TW-1:0]     eff_t,
  input  wire logic [TW-2:0]     margin_x,
  input  wire logic [TW-2:0]     margin_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nnls_pkg::out_item_t    out_item
);

  import nnls_pkg::*;

  localparam int PW = 2 * TW;

  typedef struct packed {
    logic [15:0]   pixel;
    logic [TW-1:0] row_first;
    logic [TW-1:0] row_count;
    logic [TW-1:0] col_first;
    logic [TW-1:0] col_count;
    logic [RW-1:0] run_len;
    logic          ovf;
    logic          last;
    logic          complete;
  } job_t;

  back_state_t state_r, state_nxt;
  job_t          job_r, job_nxt, head;
  logic [PW-1:0] row_addr_r, row_addr_nxt, addr_r, addr_nxt;
  logic [TW-1:0] j_r, j_nxt;
  logic [RW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          slot_free, emit, status, final_one, lor;
  logic [PW-1:0] base_addr;

  assign head      = job_t'(q_data);
  assign slot_free = !out_valid_r || !out_stall;
  assign status    = job_r.run_len == '0;
  assign lor       = RW'(k_r + RW'(1)) == job_r.run_len;
  assign final_one = status || lor;
  assign base_addr = (PW'(margin_y) + PW'(head.row_first)) * PW'(eff_t)
                     + PW'(margin_x) + PW'(head.col_first);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: if (slot_free && final_one) begin
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_EMIT: emit  = slot_free;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    job_nxt      = job_r;
    row_addr_nxt = row_addr_r;
    addr_nxt     = addr_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    out_nxt      = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (q_pop) begin
      job_nxt      = head;
      row_addr_nxt = base_addr;
      addr_nxt     = base_addr;
      j_nxt        = '0;
      k_nxt        = '0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (status) begin
        out_nxt.target_address = '0;
        out_nxt.pixel_value    = '0;
        out_nxt.write_enable   = 1'b0;
        out_nxt.last_of_run    = 1'b1;
        out_nxt.frame_complete = job_r.complete;
        out_nxt.overflow       = 1'b0;
      end else begin
        out_nxt.target_address = ADDR_W'(addr_r);
        out_nxt.pixel_value    = job_r.pixel;
        out_nxt.write_enable   = 1'b1;
        out_nxt.last_of_run    = lor;
        out_nxt.frame_complete = lor && job_r.last && job_r.complete;
        out_nxt.overflow       = job_r.ovf;
      end
      k_nxt = k_r + RW'(1);
      if (TW'(j_r + TW'(1)) == job_r.col_count) begin
        j_nxt        = '0;
        row_addr_nxt = row_addr_r + PW'(eff_t);
        addr_nxt     = row_addr_r + PW'(eff_t);
      end else begin
        j_nxt    = j_r + TW'(1);
        addr_nxt = addr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    row_addr_r <= row_addr_nxt;
    addr_r     <= addr_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### sv/nearest_neighbor_letterbox_scaler_unit.sv
// top level of the nearest-neighbor letterbox scaler: registers, front, queue, back
`default_nettype none

// Source pixels enter in raster order and leave as RGB565 write transactions into a
// square target frame. For each source pixel the front scans the target rows (only at
// the first pixel of a source row) and then the target columns that the pixel covers,
// one per cycle with running sums instead of a divider, multiplies the two counts and
// pushes the job. It waits to push only while the job queue is full. The back loads a
// job from the two-entry job queue and then sends one transaction per cycle while the
// output is not stalled. After reset and after every register write the front works
// out the letterbox geometry in a one-bit-per-cycle divider and takes no pixel.

module nearest_neighbor_letterbox_scaler_unit #(
  parameter int MAX_TARGET = nnls_pkg::MAX_TARGET_DEF,
  parameter int MAX_SOURCE = nnls_pkg::MAX_SOURCE_DEF,
  parameter int MAX_RUN    = nnls_pkg::MAX_RUN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire nnls_pkg::in_item_t               in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output nnls_pkg::out_item_t                   out_item,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [nnls_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [nnls_pkg::PDATA_W-1:0]     pwdata,
  output logic [nnls_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  import nnls_pkg::*;

  localparam int TW = $clog2(MAX_TARGET + 1);
  localparam int SW = $clog2(MAX_SOURCE + 1);
  localparam int RW = $clog2(MAX_RUN + 1);
  localparam int JW = 16 + 4 * TW + RW + 3;

  logic [SRC_REG_W-1:0] src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [TGT_REG_W-1:0] tgt_r, tgt_nxt;
  logic                 keep_r, keep_nxt, packed_r, packed_nxt;
  logic                 wr, restart;
  reg_idx_t             idx;

  logic [SW-1:0] eff_w, eff_h;
  logic [TW-1:0] eff_t;
  logic [TW-2:0] margin_x, margin_y;

  logic          q_push, q_full, q_pop, q_valid;
  logic [JW-1:0] q_din, q_dout;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    src_w_nxt  = src_w_r;
    src_h_nxt  = src_h_r;
    tgt_nxt    = tgt_r;
    keep_nxt   = keep_r;
    packed_nxt = packed_r;
    restart    = 1'b0;
    prdata     = '0;
    case (idx)
      REG_SOURCE_WIDTH: begin
        prdata  = PDATA_W'(src_w_r);
        restart = wr;
        if (wr) begin
          src_w_nxt = pwdata[SRC_REG_W-1:0];
        end
      end
      REG_SOURCE_HEIGHT: begin
        prdata  = PDATA_W'(src_h_r);
        restart = wr;
        if (wr) begin
          src_h_nxt = pwdata[SRC_REG_W-1:0];
        end
      end
      REG_TARGET_SIZE: begin
        prdata  = PDATA_W'(tgt_r);
        restart = wr;
        if (wr) begin
          tgt_nxt = pwdata[TGT_REG_W-1:0];
        end
      end
      REG_KEEP_ASPECT: begin
        prdata  = PDATA_W'(keep_r);
        restart = wr;
        if (wr) begin
          keep_nxt = pwdata[0];
        end
      end
      REG_PACKED_MODE: begin
        prdata  = PDATA_W'(packed_r);
        restart = wr;
        if (wr) begin
          packed_nxt = pwdata[0];
        end
      end
      default: begin
        prdata  = '0;
        restart = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= SRC_REG_W'(1);
      src_h_r  <= SRC_REG_W'(1);
      tgt_r    <= TGT_REG_W'(1);
      keep_r   <= 1'b0;
      packed_r <= 1'b1;
    end else begin
      src_w_r  <= src_w_nxt;
      src_h_r  <= src_h_nxt;
      tgt_r    <= tgt_nxt;
      keep_r   <= keep_nxt;
      packed_r <= packed_nxt;
    end
  end

  // saturate sizes to the supported range
  assign eff_w = (src_w_r == '0) ? SW'(1) :
                 (32'(src_w_r) > MAX_SOURCE) ? SW'(MAX_SOURCE) : SW'(src_w_r);
  assign eff_h = (src_h_r == '0) ? SW'(1) :
                 (32'(src_h_r) > MAX_SOURCE) ? SW'(MAX_SOURCE) : SW'(src_h_r);
  assign eff_t = (tgt_r == '0) ? TW'(1) :
                 (32'(tgt_r) > MAX_TARGET) ? TW'(MAX_TARGET) : TW'(tgt_r);

  nnls_front #(
    .MAX_TARGET (MAX_TARGET),
    .MAX_SOURCE (MAX_SOURCE),
    .MAX_RUN    (MAX_RUN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .eff_t       (eff_t),
    .keep_aspect (keep_r),
    .packed_mode (packed_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_push      (q_push),
    .q_data      (q_din),
    .q_full      (q_full),
    .margin_x    (margin_x),
    .margin_y    (margin_y)
  );

  nnls_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_valid)
  );

  nnls_back #(
    .MAX_TARGET (MAX_TARGET),
    .MAX_RUN    (MAX_RUN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_dout),
    .eff_t     (eff_t),
    .margin_x  (margin_x),
    .margin_y  (margin_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front took a second pixel back to back");

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.write_enable |-> out_item.last_of_run && !out_item.overflow)
    else $error("status transaction not closing its run");

  a_complete_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_complete |-> out_item.last_of_run)
    else $error("frame_complete outside the last transaction of a run");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job queue popped while empty");
`endif

endmodule

`default_nettype wire
